// ===== hdl/vpr_pkg.sv =====
package vpr_pkg;

    localparam int CMAP_ENTRIES = 256;
    localparam int ADDR_W       = $clog2(CMAP_ENTRIES);
    localparam int COUNT_W      = ADDR_W + 1;
    localparam int DIV_STAGES   = 16;

    localparam logic [2:0] VC_STATIC_GRAY  = 3'd0;
    localparam logic [2:0] VC_GRAY_SCALE   = 3'd1;
    localparam logic [2:0] VC_STATIC_COLOR = 3'd2;
    localparam logic [2:0] VC_PSEUDO_COLOR = 3'd3;
    localparam logic [2:0] VC_TRUE_COLOR   = 3'd4;
    localparam logic [2:0] VC_DIRECT_COLOR = 3'd5;

    typedef enum logic [2:0] {
        REG_CLASS = 3'd0,
        REG_DEPTH = 3'd1,
        REG_RMASK = 3'd2,
        REG_GMASK = 3'd3,
        REG_BMASK = 3'd4,
        REG_COUNT = 3'd5
    } t_reg;

    typedef enum logic [1:0] {
        K_SCALE = 2'd0,
        K_LUT   = 2'd1,
        K_MONO  = 2'd2
    } t_kind;

    // index of the lowest set bit, 0 for an all-zero word
    function automatic logic [4:0] low_bit(input logic [31:0] v);
        logic [4:0] r;
        r = '0;
        for (int i = 31; i >= 0; i--) begin
            if (v[i]) r = 5'(i);
        end
        return r;
    endfunction

    // (c + 128) / 257: x / 256 overshoots the quotient by at most one
    function automatic logic [7:0] to8(input logic [15:0] c);
        logic [16:0] x;
        logic [8:0]  e;
        logic [17:0] p;
        x = {1'b0, c} + 17'd128;
        e = x[16:8];
        p = {1'b0, e, 8'b0} + {9'b0, e};
        if (p > {1'b0, x}) e = e - 9'd1;
        return e[7:0];
    endfunction

endpackage

// ===== hdl/visual_pixel_to_rgb.sv =====
// visual_pixel_to_rgb: X visual pixel to 8-bit rgb
// input channel i_valid/o_ready carries one item: a convert item (i_action 0)
// gives exactly one result, a colormap write item (i_action 1) gives none and
// updates the three colormap columns at i_entry_index in the accept cycle.
// output channel o_valid/i_ready carries status and the three components.
// configuration registers are to be written by the user through i_cfg_we/i_cfg_idx/
// i_cfg_data only while no item is in flight; the block itself does not enforce this.
// pipeline: field extraction and the colormap read are registered at the accept
// edge, then sixteen stages of the pipelined restoring divider (one quotient bit
// per stage) scale masked fields, and the final selection with the 16-to-8 bit
// rounding is registered into the output register.
// throughput: one item per cycle; the colormap columns are separate
// synchronous memories, each read at one address and written at one.
// when the receiver stalls the whole pipeline holds and o_ready drops only
// while the output register is full and i_ready is low.
// reset (synchronous, active low) clears the pipeline valid flags, sets static gray,
// depth 8, zero masks and count; colormap contents are undefined until written.
module visual_pixel_to_rgb (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic [31:0] i_pixel_value,
    input  logic [7:0]  i_entry_index,
    input  logic [15:0] i_entry_red,
    input  logic [15:0] i_entry_green,
    input  logic [15:0] i_entry_blue,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_status,
    output logic [7:0]  o_out_red,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_blue,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    localparam int NS = vpr_pkg::DIV_STAGES;

    logic [2:0]  r_class;
    logic [5:0]  r_depth;
    logic [31:0] r_mask [3];
    logic [vpr_pkg::COUNT_W-1:0] r_count;

    logic [15:0] r_mem_r [vpr_pkg::CMAP_ENTRIES];
    logic [15:0] r_mem_g [vpr_pkg::CMAP_ENTRIES];
    logic [15:0] r_mem_b [vpr_pkg::CMAP_ENTRIES];
    logic [15:0] r_rd [3];

    logic            r_v    [0:NS];
    logic            r_bad  [0:NS];
    vpr_pkg::t_kind  r_kind [0:NS];
    logic            r_mono [0:NS];
    logic [31:0]     r_f    [3];
    logic [47:0]     r_rem  [1:NS][3];
    logic [15:0]     r_quo  [1:NS][3];
    logic [23:0]     r_lut  [1:NS];

    logic        r_ov;
    logic        r_ost;
    logic [7:0]  r_oc [3];

    logic        en, acc;
    logic        direct, gray, cfg_bad;
    vpr_pkg::t_kind kind;
    logic [31:0] dm;
    logic [31:0] mk [3];
    logic [4:0]  tz [3];
    logic [31:0] m_c [3];
    logic [31:0] fld [3];
    logic [vpr_pkg::ADDR_W-1:0] addr [3];
    logic        idx_bad;
    logic        n_bad;
    logic [7:0]  fin [3];

    assign en      = !r_ov || i_ready;
    assign o_ready = en;
    assign acc     = i_valid && en;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class   <= vpr_pkg::VC_STATIC_GRAY;
            r_depth   <= 6'd8;
            r_mask[0] <= '0;
            r_mask[1] <= '0;
            r_mask[2] <= '0;
            r_count   <= '0;
        end else if (i_cfg_we) begin
            case (vpr_pkg::t_reg'(i_cfg_idx))
                vpr_pkg::REG_CLASS: r_class   <= i_cfg_data[2:0];
                vpr_pkg::REG_DEPTH: r_depth   <= i_cfg_data[5:0];
                vpr_pkg::REG_RMASK: r_mask[0] <= i_cfg_data;
                vpr_pkg::REG_GMASK: r_mask[1] <= i_cfg_data;
                vpr_pkg::REG_BMASK: r_mask[2] <= i_cfg_data;
                vpr_pkg::REG_COUNT: r_count   <= i_cfg_data[vpr_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // decode of the settings; keeping them stable while items are in flight is up to the user
    always_comb begin
        direct = r_class == vpr_pkg::VC_TRUE_COLOR || r_class == vpr_pkg::VC_DIRECT_COLOR;
        gray   = r_class == vpr_pkg::VC_STATIC_GRAY || r_class == vpr_pkg::VC_GRAY_SCALE;
        dm     = 32'hffff_ffff >> (6'd32 - r_depth);
        cfg_bad = 1'b0;
        kind    = vpr_pkg::K_SCALE;
        if (r_class > vpr_pkg::VC_DIRECT_COLOR || r_depth == 6'd0 || r_depth > 6'd32 ||
            r_count > vpr_pkg::COUNT_W'(vpr_pkg::CMAP_ENTRIES)) begin
            cfg_bad = 1'b1;
        end else if (direct && r_mask[0] == '0 && r_mask[1] == '0 && r_mask[2] == '0) begin
            cfg_bad = 1'b1;
        end else if (!direct && r_count == '0 && !gray) begin
            cfg_bad = 1'b1;
        end else if (!direct && r_count == '0) begin
            kind = (r_depth == 6'd1) ? vpr_pkg::K_MONO : vpr_pkg::K_SCALE;
        end else if (r_count != '0) begin
            kind = vpr_pkg::K_LUT;
        end
        for (int c = 0; c < 3; c++) begin
            mk[c]  = (!direct && r_count == '0) ? dm : r_mask[c];
            tz[c]  = vpr_pkg::low_bit(mk[c]);
            m_c[c] = mk[c] >> tz[c];
        end
    end

    // field extraction and index check for the item at the input
    always_comb begin
        idx_bad = 1'b0;
        for (int c = 0; c < 3; c++) begin
            fld[c] = (i_pixel_value & mk[c]) >> tz[c];
            if (direct) begin
                addr[c] = fld[c][vpr_pkg::ADDR_W-1:0];
                if (fld[c] >= {{(32-vpr_pkg::COUNT_W){1'b0}}, r_count}) idx_bad = 1'b1;
            end else begin
                addr[c] = i_pixel_value[vpr_pkg::ADDR_W-1:0];
            end
        end
        if (!direct && i_pixel_value >= {{(32-vpr_pkg::COUNT_W){1'b0}}, r_count})
            idx_bad = 1'b1;
        n_bad = cfg_bad || (kind == vpr_pkg::K_LUT && idx_bad);
    end

    // colormap columns
    always_ff @(posedge i_clk) begin
        if (acc && i_action) begin
            r_mem_r[i_entry_index] <= i_entry_red;
            r_mem_g[i_entry_index] <= i_entry_green;
            r_mem_b[i_entry_index] <= i_entry_blue;
        end
        if (en) begin
            r_rd[0] <= r_mem_r[addr[0]];
            r_rd[1] <= r_mem_g[addr[1]];
            r_rd[2] <= r_mem_b[addr[2]];
        end
    end

    // control pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= NS; j++) r_v[j] <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v[0] <= acc && !i_action;
            for (int j = 0; j < NS; j++) r_v[j+1] <= r_v[j];
            r_ov <= r_v[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bad[0]  <= n_bad;
            r_kind[0] <= kind;
            r_mono[0] <= (i_pixel_value & dm) != '0;
            for (int c = 0; c < 3; c++) r_f[c] <= fld[c];
            for (int j = 0; j < NS; j++) begin
                r_bad[j+1]  <= r_bad[j];
                r_kind[j+1] <= r_kind[j];
                r_mono[j+1] <= r_mono[j];
            end
            r_lut[1] <= {vpr_pkg::to8(r_rd[0]), vpr_pkg::to8(r_rd[1]), vpr_pkg::to8(r_rd[2])};
            for (int j = 1; j < NS; j++) r_lut[j+1] <= r_lut[j];
        end
    end

    // restoring divider: f * 65535 / m, one quotient bit per stage
    for (genvar j = 0; j < NS; j++) begin : g_div
        logic [47:0] w_rin  [3];
        logic [15:0] w_qin  [3];
        logic [47:0] w_dv   [3];
        logic [47:0] w_rout [3];
        logic [15:0] w_qout [3];

        if (j == 0) begin : g_first
            always_comb begin
                for (int c = 0; c < 3; c++) begin
                    w_rin[c] = {r_f[c], 16'b0} - {16'b0, r_f[c]};
                    w_qin[c] = '0;
                end
            end
        end else begin : g_rest
            always_comb begin
                for (int c = 0; c < 3; c++) begin
                    w_rin[c] = r_rem[j][c];
                    w_qin[c] = r_quo[j][c];
                end
            end
        end

        always_comb begin
            for (int c = 0; c < 3; c++) begin
                w_dv[c] = {16'b0, m_c[c]} << (NS - 1 - j);
                if (w_rin[c] >= w_dv[c]) begin
                    w_rout[c] = w_rin[c] - w_dv[c];
                    w_qout[c] = w_qin[c] | (16'd1 << (NS - 1 - j));
                end else begin
                    w_rout[c] = w_rin[c];
                    w_qout[c] = w_qin[c];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int c = 0; c < 3; c++) begin
                    r_rem[j+1][c] <= w_rout[c];
                    r_quo[j+1][c] <= w_qout[c];
                end
            end
        end
    end

    // final selection and rounding
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            case (r_kind[NS])
                vpr_pkg::K_LUT:   fin[c] = r_lut[NS][23-8*c -: 8];
                vpr_pkg::K_MONO:  fin[c] = r_mono[NS] ? 8'd0 : 8'd255;
                vpr_pkg::K_SCALE: fin[c] = (mk[c] == '0) ? 8'd0 : vpr_pkg::to8(r_quo[NS][c]);
                default:          fin[c] = 8'd0;
            endcase
            if (r_bad[NS]) fin[c] = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ost <= r_bad[NS];
            for (int c = 0; c < 3; c++) r_oc[c] <= fin[c];
        end
    end

    assign o_valid     = r_ov;
    assign o_status    = r_ost;
    assign o_out_red   = r_oc[0];
    assign o_out_green = r_oc[1];
    assign o_out_blue  = r_oc[2];

endmodule

// ===== hdl/vpr_checker.sv =====
module vpr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_status,
    input logic [7:0]  o_out_red,
    input logic [7:0]  o_out_green,
    input logic [7:0]  o_out_blue
);

    // an invalid pixel carries no color
    a_bad_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (o_out_red == 8'd0 && o_out_green == 8'd0 &&
                                   o_out_blue == 8'd0))
        else $error("invalid result with nonzero color");

    // input side only stalls behind a full, stalled output
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || i_ready) |-> o_ready)
        else $error("input stalled without output backpressure");

    // pipeline is empty right after reset
    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result present after reset");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_status) && $stable(o_out_red) &&
                                   $stable(o_out_green) && $stable(o_out_blue)))
        else $error("stalled result changed");

endmodule

bind visual_pixel_to_rgb vpr_checker u_vpr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_status    (o_status),
    .o_out_red   (o_out_red),
    .o_out_green (o_out_green),
    .o_out_blue  (o_out_blue)
);
